>>> design/lcs_pkg.sv
// Shared types and constants for the longest common substring unit.
package lcs_pkg;

  localparam int SYM_W  = 8;
  localparam int CELL_W = 9;
  localparam logic [CELL_W-1:0] CELL_MAX = {CELL_W{1'b1}};

  // Broadcast controls sent to every cell of the row
  typedef struct packed {
    logic             step;    // update the row with the query symbol
    logic             clear;   // return the cell to its empty state
    logic [SYM_W-1:0] symbol;  // reference symbol on load, query symbol on step
  } cell_ctrl_t;

endpackage

>>> design/longest_common_substring_unit.sv
// Top level of the longest common substring unit: control, cell row and result register.
//
// Usage:
//   Input channel (in_*): one request per symbol. in_tuser = 0 loads a reference
//   symbol into the next free column, in_tuser = 1 streams a query symbol; in_tlast
//   on a query request marks the end of the query (ignored on a load).
//   Each query symbol updates every column of the cell row in the same cycle, so
//   loads and query symbols are taken at one request per cycle outside the drain.
//   After the last query symbol the per-column bests are reduced through the cell
//   chain: in_tready stays low during the drain, the result is then registered
//   on the out_* channel, and the whole block (reference included) clears itself.
//   Results: out_tdata carries start offset and length, out_tuser the overflow flag.
//   A stalled result is held in the output register; new symbols are accepted
//   meanwhile, and only the end of the next query waits until the result is taken.
//   Reset (rst_n low, synchronous) empties the reference, the row and the bests.
//   Symbols beyond MAX_REF_LEN or MAX_QUERY_LEN are dropped and set the overflow flag.
//
module longest_common_substring_unit #(
  parameter int MAX_REF_LEN   = 256,
  parameter int MAX_QUERY_LEN = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tuser,   // [0] func
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] start_res, [24:16] length, [31:25] zero
  output logic        out_tuser   // [0] overflow
);
  import lcs_pkg::*;

  localparam int RW = $clog2(MAX_REF_LEN + 1);
  localparam int QW = $clog2(MAX_QUERY_LEN + 1);
  localparam int DW = (QW > 16) ? QW : 16;
  localparam logic [RW-1:0] REF_FULL = RW'(MAX_REF_LEN);
  localparam logic [QW-1:0] QRY_FULL = QW'(MAX_QUERY_LEN);

  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [RW-1:0]     ref_count_r, ref_count_nxt;
  logic [QW-1:0]     query_pos_r, query_pos_nxt;
  logic              overflowed_r, overflowed_nxt;
  logic [RW-1:0]     drain_cnt_r, drain_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_start_r, out_start_nxt;
  logic [CELL_W-1:0] out_len_r, out_len_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              in_accept;
  logic              load_req;
  logic              query_req;
  logic              ref_full;
  logic              qry_full;
  logic              capture;
  cell_ctrl_t        ctrl;
  logic [QW-1:0]     row_idx;
  logic [DW-1:0]     start_full;

  logic [CELL_W-1:0] val_w     [0:MAX_REF_LEN];
  logic [CELL_W-1:0] red_len_w [0:MAX_REF_LEN];
  logic [QW-1:0]     red_row_w [0:MAX_REF_LEN];

  assign in_tready = (state_r == ST_RUN);
  assign in_accept = in_tvalid && in_tready;
  assign load_req  = in_accept && !in_tuser;
  assign query_req = in_accept && in_tuser;
  assign ref_full  = (ref_count_r == REF_FULL);
  assign qry_full  = (query_pos_r == QRY_FULL);

  // Drain done and the output register is free: latch the result, clear the row
  assign capture = (state_r == ST_DRAIN) && (drain_cnt_r == REF_FULL) &&
                   (!out_valid_r || out_tready);

  assign ctrl.step   = query_req && !qry_full;
  assign ctrl.clear  = capture;
  assign ctrl.symbol = in_tdata;
  assign row_idx     = query_pos_r + QW'(1);

  // Left border of the table and seed of the reduction chain
  assign val_w[0]     = '0;
  assign red_len_w[0] = '0;
  assign red_row_w[0] = '0;

  for (genvar i = 0; i < MAX_REF_LEN; i++) begin : g_cell
    lcs_cell #(
      .ROW_W (QW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl_i     (ctrl),
      .load_i     (load_req && (ref_count_r == RW'(i))),
      .row_i      (row_idx),
      .left_val_i (val_w[i]),
      .val_o      (val_w[i+1]),
      .red_len_i  (red_len_w[i]),
      .red_row_i  (red_row_w[i]),
      .red_len_o  (red_len_w[i+1]),
      .red_row_o  (red_row_w[i+1])
    );
  end

  assign start_full = DW'(red_row_w[MAX_REF_LEN]) - DW'(red_len_w[MAX_REF_LEN]);

  always_comb begin
    state_nxt      = state_r;
    ref_count_nxt  = ref_count_r;
    query_pos_nxt  = query_pos_r;
    overflowed_nxt = overflowed_r;
    drain_cnt_nxt  = drain_cnt_r;
    out_valid_nxt  = out_valid_r;
    out_start_nxt  = out_start_r;
    out_len_nxt    = out_len_r;
    out_ovf_nxt    = out_ovf_r;

    // Append a reference column, or flag the overflow when the row is full
    if (load_req) begin
      if (ref_full) begin
        overflowed_nxt = 1'b1;
      end else begin
        ref_count_nxt = ref_count_r + RW'(1);
      end
    end

    if (query_req) begin
      if (qry_full) begin
        overflowed_nxt = 1'b1;
      end else begin
        query_pos_nxt = query_pos_r + QW'(1);
      end
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_RUN: begin
        if (query_req && in_tlast) begin
          state_nxt     = ST_DRAIN;
          drain_cnt_nxt = '0;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt_r != REF_FULL) begin
          drain_cnt_nxt = drain_cnt_r + RW'(1);
        end else if (capture) begin
          state_nxt      = ST_RUN;
          out_valid_nxt  = 1'b1;
          out_start_nxt  = start_full[15:0];
          out_len_nxt    = red_len_w[MAX_REF_LEN];
          out_ovf_nxt    = overflowed_r;
          ref_count_nxt  = '0;
          query_pos_nxt  = '0;
          overflowed_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RUN;
      ref_count_r  <= '0;
      query_pos_r  <= '0;
      overflowed_r <= 1'b0;
      drain_cnt_r  <= '0;
      out_valid_r  <= 1'b0;
      out_start_r  <= '0;
      out_len_r    <= '0;
      out_ovf_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ref_count_r  <= ref_count_nxt;
      query_pos_r  <= query_pos_nxt;
      overflowed_r <= overflowed_nxt;
      drain_cnt_r  <= drain_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      out_start_r  <= out_start_nxt;
      out_len_r    <= out_len_nxt;
      out_ovf_r    <= out_ovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_len_r, out_start_r};
  assign out_tuser  = out_ovf_r;

  a_ref_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    ref_count_r <= REF_FULL)
    else $error("reference count beyond capacity");

  a_query_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    query_pos_r <= QRY_FULL)
    else $error("query position beyond capacity");

  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (drain_cnt_r <= REF_FULL))
    else $error("drain counter ran past the chain length");

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    capture |=> (ref_count_r == '0) && (query_pos_r == '0) && !overflowed_r &&
                out_valid_r)
    else $error("block not cleared after result");

  a_empty_result_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_len_r == '0)) |-> (out_start_r == '0))
    else $error("empty match reports a nonzero start");

endmodule

>>> design/lcs_cell.sv
// One column of the match-run row: reference symbol, run length and per-column best.
module lcs_cell #(
  parameter int ROW_W = 17
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lcs_pkg::cell_ctrl_t        ctrl_i,
  input  logic                       load_i,
  input  logic [ROW_W-1:0]           row_i,
  input  logic [lcs_pkg::CELL_W-1:0] left_val_i,
  output logic [lcs_pkg::CELL_W-1:0] val_o,
  input  logic [lcs_pkg::CELL_W-1:0] red_len_i,
  input  logic [ROW_W-1:0]           red_row_i,
  output logic [lcs_pkg::CELL_W-1:0] red_len_o,
  output logic [ROW_W-1:0]           red_row_o
);
  import lcs_pkg::*;

  logic [SYM_W-1:0]  sym_r;
  logic              valid_r, valid_nxt;
  logic [CELL_W-1:0] val_r, val_nxt;
  logic [CELL_W-1:0] best_r, best_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CELL_W-1:0] red_len_r;
  logic [ROW_W-1:0]  red_row_r;
  logic [CELL_W-1:0] run_inc;
  logic [CELL_W-1:0] val_new;
  logic              match;
  logic              take_own;

  assign match   = valid_r && (sym_r == ctrl_i.symbol);
  assign run_inc = (left_val_i == CELL_MAX) ? CELL_MAX : left_val_i + CELL_W'(1);
  assign val_new = match ? run_inc : '0;

  always_comb begin
    valid_nxt = valid_r;
    val_nxt   = val_r;
    best_nxt  = best_r;
    row_nxt   = row_r;
    priority if (ctrl_i.clear) begin
      valid_nxt = 1'b0;
      val_nxt   = '0;
      best_nxt  = '0;
      row_nxt   = '0;
    end else if (load_i) begin
      valid_nxt = 1'b1;
      val_nxt   = '0;
    end else if (ctrl_i.step) begin
      val_nxt = val_new;
      // keep the earliest row that reached this column's longest run
      if (val_new > best_r) begin
        best_nxt = val_new;
        row_nxt  = row_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      val_r   <= '0;
      best_r  <= '0;
      row_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      val_r   <= val_nxt;
      best_r  <= best_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      sym_r <= ctrl_i.symbol;
    end
  end

  // Reduction chain: longer run wins, equal runs go to the earlier row
  assign take_own = (best_r > red_len_i) ||
                    ((best_r == red_len_i) && (row_r < red_row_i));

  always_ff @(posedge clk) begin
    red_len_r <= take_own ? best_r : red_len_i;
    red_row_r <= take_own ? row_r  : red_row_i;
  end

  assign val_o     = val_r;
  assign red_len_o = red_len_r;
  assign red_row_o = red_row_r;

endmodule

>>> verif/tb_longest_common_substring_unit.sv
// Self-checking testbench for the longest common substring unit: directed cases, random traffic, back-pressure.
module tb_longest_common_substring_unit;
  import lcs_pkg::*;

  localparam int REF_DEPTH      = 256;
  localparam int QUERY_DEPTH    = 65536;
  localparam int DRAIN_WAIT     = REF_DEPTH + 20;
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int STALL_CYCLES   = 1500;
  localparam int REPORT_MAX     = 10;
  localparam int FULL_REF_QUERY = 32;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } lcs_func_e;

  typedef struct packed {
    logic [15:0]       start;
    logic [CELL_W-1:0] length;
    logic              overflow;
  } lcs_match_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [7:0] symbol
  logic        in_tuser   = 1'b0; // [0] func
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [15:0] start_res, [24:16] length, [31:25] zero
  logic        out_tuser;         // [0] overflow

  // Predictor state: loaded reference, current row of run lengths, best so far
  logic [SYM_W-1:0]  ref_sym [REF_DEPTH];
  logic [CELL_W-1:0] run_row [REF_DEPTH];
  int unsigned       ref_len;
  int unsigned       query_rows;
  int unsigned       best_len;
  int unsigned       best_row;
  bit                truncated;
  lcs_match_t        expected_matches[$];

  int unsigned tx_idle_pct    = 0;
  int unsigned rx_idle_pct    = 0;
  int unsigned requests_sent  = 0;
  int unsigned results_due    = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  int unsigned stall_requests = 0;
  int unsigned stall_seen     = 0;
  int unsigned stall_left     = 0;

  longest_common_substring_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // Return the predictor to its reset state; the block does the same after each result.
  function automatic void clear_model();
    foreach (run_row[i]) begin
      run_row[i] = '0;
      ref_sym[i] = '0;
    end
    ref_len    = 0;
    query_rows = 0;
    best_len   = 0;
    best_row   = 0;
    truncated  = 1'b0;
  endfunction

  // Advance the predictor by one accepted request and queue the result it causes.
  function automatic void predict_request(lcs_func_e func, logic [7:0] sym, logic last);
    int unsigned       row_max;
    logic [CELL_W-1:0] diag;
    logic [CELL_W-1:0] run_val;
    lcs_match_t        m;
    if (func == FUNC_LOAD) begin
      // append a column; a full reference drops the symbol and flags overflow
      if (ref_len < REF_DEPTH) begin
        ref_sym[ref_len] = sym;
        run_row[ref_len] = '0;
        ref_len++;
      end else begin
        truncated = 1'b1;
      end
      return;
    end
    if (query_rows < QUERY_DEPTH) begin
      row_max = 0;
      // walk right to left so each diagonal still holds the previous row
      for (int col = int'(ref_len) - 1; col >= 0; col--) begin
        diag = (col > 0) ? run_row[col-1] : '0;
        run_val = '0;
        if (ref_sym[col] == sym)
          run_val = (diag == CELL_MAX) ? CELL_MAX : diag + 1'b1;
        run_row[col] = run_val;
        if (run_val > row_max)
          row_max = 32'(run_val);
      end
      query_rows++;
      // strict compare: a tie in a later row keeps the earlier best
      if (row_max > best_len) begin
        best_len = row_max;
        best_row = query_rows;
      end
    end else begin
      truncated = 1'b1;
    end
    if (last) begin
      m.start    = 16'(best_row - best_len);
      m.length   = CELL_W'(best_len);
      m.overflow = truncated;
      expected_matches.push_back(m);
      results_due++;
      clear_model();
    end
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("[%0t] mismatch in %s: expected %0d, got %0d", $time, what, want, got);
  endfunction

  // Offer one request with random idle gaps ahead of it, hold until accepted.
  task automatic send_request(lcs_func_e func, logic [7:0] sym, logic last);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= sym;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    predict_request(func, sym, last);
    requests_sent++;
  endtask

  // Drop valid and hold the sender until every queued result has been taken.
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_matches.size() != 0)
      @(posedge clk);
  endtask

  // Check for no match at the symbol extremes, and a query against an empty reference.
  task automatic test_no_match();
    send_request(FUNC_LOAD, 8'h00, 1'b0);
    send_request(FUNC_LOAD, 8'hFF, 1'b0);
    send_request(FUNC_QUERY, 8'h55, 1'b0);
    send_request(FUNC_QUERY, 8'hAA, 1'b1);
    send_request(FUNC_QUERY, 8'hFF, 1'b1);
    wait_results_drained();
  endtask

  // Check that an equal run in a later row does not move the best.
  task automatic test_tie_rule();
    send_request(FUNC_LOAD, 8'h00, 1'b0);
    send_request(FUNC_LOAD, 8'hFF, 1'b0);
    send_request(FUNC_LOAD, 8'h80, 1'b0);
    send_request(FUNC_LOAD, 8'h01, 1'b0);
    send_request(FUNC_QUERY, 8'hFF, 1'b0);
    send_request(FUNC_QUERY, 8'h80, 1'b0);
    send_request(FUNC_QUERY, 8'h7F, 1'b0);
    send_request(FUNC_QUERY, 8'h00, 1'b0);
    send_request(FUNC_QUERY, 8'hFF, 1'b1);
    wait_results_drained();
  endtask

  // Check that last is ignored on a load and that a load during a query adds a column.
  task automatic test_load_order();
    send_request(FUNC_LOAD, 8'h41, 1'b1);
    send_request(FUNC_QUERY, 8'h41, 1'b0);
    send_request(FUNC_LOAD, 8'h42, 1'b0);
    send_request(FUNC_QUERY, 8'h42, 1'b1);
    wait_results_drained();
  endtask

  // Fill the reference, overrun it by one, then match a stretch that ends at the last column.
  task automatic test_full_reference();
    logic [7:0]  syms[REF_DEPTH];
    int unsigned origin;
    foreach (syms[i])
      syms[i] = 8'($urandom);
    foreach (syms[i])
      send_request(FUNC_LOAD, syms[i], 1'b0);
    send_request(FUNC_LOAD, 8'($urandom), 1'b0);
    origin = REF_DEPTH - FULL_REF_QUERY;
    for (int i = 0; i < FULL_REF_QUERY; i++)
      send_request(FUNC_QUERY, syms[origin + i], i == FULL_REF_QUERY - 1);
    wait_results_drained();
  endtask

  // Stall the receiver long enough that a held result blocks the end of later queries.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    stall_requests++;
    repeat (4) begin
      send_request(FUNC_LOAD, 8'hC3, 1'b0);
      send_request(FUNC_LOAD, 8'h3C, 1'b0);
      send_request(FUNC_QUERY, 8'($urandom), 1'b0);
      send_request(FUNC_QUERY, 8'hC3, 1'b0);
      send_request(FUNC_QUERY, 8'h3C, 1'b1);
    end
    wait_results_drained();
  endtask

  // One random sequence: mostly a well-formed reference and query, sometimes noise.
  task automatic run_random_sequence();
    logic [7:0]  ref_q[$];
    logic [7:0]  sym;
    int unsigned kind;
    int unsigned n_ref;
    int unsigned n_query;
    int unsigned base;
    int unsigned origin;
    bit          narrow;
    bit          copy;
    kind = $urandom_range(9, 0);
    if (kind == 0) begin
      // noise: any field values, open queries and last on loads included
      repeat ($urandom_range(8, 1))
        send_request(lcs_func_e'($urandom_range(1, 0)), 8'($urandom),
                     1'($urandom_range(1, 0)));
      return;
    end
    if (kind == 2)
      n_ref = 0;
    else if ($urandom_range(19, 0) == 0)
      n_ref = $urandom_range(REF_DEPTH, 100);
    else
      n_ref = $urandom_range(16, 1);
    base   = $urandom_range(255, 0);
    narrow = $urandom_range(1, 0);
    for (int i = 0; i < n_ref; i++) begin
      sym = narrow ? 8'(base + $urandom_range(3, 0)) : 8'($urandom);
      ref_q.push_back(sym);
      send_request(FUNC_LOAD, sym, $urandom_range(7, 0) == 0);
    end
    n_query = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
    copy    = (ref_q.size() != 0) && ($urandom_range(2, 0) != 0);
    origin  = copy ? $urandom_range(ref_q.size() - 1, 0) : 0;
    for (int i = 0; i < n_query; i++) begin
      // late column in the middle of the query
      if (kind == 1 && i == n_query / 2)
        send_request(FUNC_LOAD, 8'(base + $urandom_range(3, 0)), 1'b0);
      if (copy && $urandom_range(5, 0) != 0)
        sym = ref_q[(origin + i) % ref_q.size()];
      else if (narrow)
        sym = 8'(base + $urandom_range(3, 0));
      else
        sym = 8'($urandom);
      send_request(FUNC_QUERY, sym, i == n_query - 1);
    end
  endtask

  // Random traffic at one idle setting until enough requests and results have passed.
  task automatic test_random_traffic(int unsigned tx_pct, int unsigned rx_pct,
                                     int unsigned n_req, int unsigned n_res);
    int unsigned req0;
    int unsigned res0;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    req0 = requests_sent;
    res0 = results_due;
    while (requests_sent - req0 < n_req || results_due - res0 < n_res)
      run_random_sequence();
    // close whatever query the noise left open
    send_request(FUNC_QUERY, 8'($urandom), 1'b1);
    wait_results_drained();
  endtask

  // Receiver: random idling, or a long hold-off counted down here when requested.
  always @(posedge clk) begin
    if (stall_seen != stall_requests) begin
      stall_seen = stall_requests;
      stall_left = STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  // Compare each taken result with the oldest expectation, field by field.
  always @(posedge clk) begin
    lcs_match_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_matches.size() == 0) begin
        note_mismatch("result with none pending", '0, out_tdata);
      end else begin
        want = expected_matches.pop_front();
        if (out_tdata[15:0] !== want.start)
          note_mismatch("start_res", want.start, out_tdata[15:0]);
        if (out_tdata[24:16] !== want.length)
          note_mismatch("length", want.length, out_tdata[24:16]);
        if (out_tuser !== want.overflow)
          note_mismatch("overflow", want.overflow, out_tuser);
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** longest_common_substring_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    clear_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 29;
    rx_idle_pct = 58;
    test_no_match();
    test_tie_rule();
    test_load_order();
    test_full_reference();

    test_random_traffic(29, 58, 70, 4);
    test_random_traffic(58, 29, 70, 4);
    test_random_traffic(0, 0, 70, 4);

    test_backpressure();

    // let any straggling result show up before the verdict
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_matches.size() == 0) begin
      $display("** longest_common_substring_unit: PASSED **");
    end else begin
      $display("** longest_common_substring_unit: FAILED **");
    end
    $finish;
  end

endmodule
